>>> rtl/buddy_page_allocator_assert.svh
// Assertion macros for the buddy page allocator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

`define BPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bpa_pkg.sv
// Shared types and constants of the buddy page allocator.
// Used by the top level and bpa_ffs; depends on nothing.
package bpa_pkg;

  localparam int WORD_W = 32;
  localparam int WBIT   = 5;
  localparam int ORD_W  = 5;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;
  localparam logic [1:0] MODE_RESERVE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] frame;
    logic [11:0] n_pages;
  } req_t;

  typedef struct packed {
    logic [15:0] frame_out;
    logic        flag;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_START,
    S_SCAN_RD,
    S_SCAN_EV,
    S_PROBE_RD,
    S_PROBE_EV,
    S_MERGE_RD,
    S_MERGE_EV,
    S_RMW_RD,
    S_RMW_WR,
    S_DONE
  } state_t;

endpackage

>>> rtl/buddy_page_allocator.sv
// Buddy page allocator: request channel in_*, result channel out_*.
// Depends on bpa_pkg, bpa_ram, bpa_ffs and buddy_page_allocator_assert.svh.
//
// Each accepted request (allocate, free, query, reserve) yields exactly one
// result. The free bitmap holds one bit per buddy-tree node, packed into
// 32-bit words of a single RAM. Every bitmap access is a read followed by an
// evaluate or write state.
// Allocate scans the bitmap words of each order from the requested one up,
// then splits the block it found down to the requested order. Free merges
// buddies upward; query and reserve probe orders from the requested one up,
// and reserve then splits. A start and a handoff state are added to every
// request; an oversized allocate, free or reserve goes from start to handoff.
// After reset the bitmap is cleared (nothing free) word by word, during
// which in_ready is low.
// While the receiver stalls, one result waits in the output register; the
// block finishes at most one more request, holds that result and takes no
// further request until the output register is free.
module buddy_page_allocator #(
  parameter int FRAME_BITS = 16,
  parameter int MAX_ORDER  = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bpa_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bpa_pkg::rsp_t out_data
);
  import bpa_pkg::*;

  localparam int TOP   = (MAX_ORDER < FRAME_BITS) ? MAX_ORDER : FRAME_BITS;
  localparam int NB    = FRAME_BITS + 1;
  localparam int AW    = NB - WBIT;
  localparam int DEPTH = 1 << AW;
  localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(TOP);

  state_t              state_r, state_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [ORD_W-1:0]    k_r, k_nxt;
  logic [ORD_W-1:0]    ord_r, ord_nxt;
  logic                over_r, over_nxt;
  logic [NB-1:0]       nd_r, nd_nxt;
  logic [AW-1:0]       wa_r, wa_nxt;
  logic                set_r, set_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;
  rsp_t                out_data_r, out_data_nxt;
  rsp_t                res_r, res_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;

  logic [WORD_W-1:0]   scan_word;
  logic                scan_found;
  logic [WBIT-1:0]     scan_pos;

  logic [ORD_W-1:0]    in_k;
  logic                in_over;

  function automatic logic [NB-1:0] node_at(input logic [ORD_W-1:0] o,
                                            input logic [FRAME_BITS-1:0] f);
    logic [NB-1:0] b;
    b = NB'(1) << (FRAME_BITS - int'(o));
    return b | NB'(f >> o);
  endfunction

  function automatic logic [AW-1:0] first_word(input logic [ORD_W-1:0] o);
    logic [NB-1:0] b;
    b = NB'(1) << (FRAME_BITS - int'(o));
    return AW'(b >> WBIT);
  endfunction

  function automatic logic [AW-1:0] last_word(input logic [ORD_W-1:0] o);
    logic [NB-1:0] b;
    b = (NB'(1) << (FRAME_BITS - int'(o) + 1)) - NB'(1);
    return AW'(b >> WBIT);
  endfunction

  function automatic logic [WORD_W-1:0] word_mask(input logic [ORD_W-1:0] o);
    int sh;
    int lo;
    logic [WORD_W-1:0] m;
    sh = FRAME_BITS - int'(o);
    m  = '1;
    if (sh < WBIT) begin
      lo = 1 << sh;
      for (int p = 0; p < WORD_W; p++) begin
        m[p] = (p >= lo) && (p < 2 * lo);
      end
    end
    return m;
  endfunction

  always_comb begin
    in_k    = TOP_ORD;
    in_over = (32'(in_data.n_pages) > (32'd1 << TOP));
    for (int i = TOP; i >= 0; i--) begin
      if (32'(in_data.n_pages) <= (32'd1 << i)) begin
        in_k = ORD_W'(i);
      end
    end
  end

  bpa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign scan_word = ram_rdata & word_mask(ord_r);

  bpa_ffs u_ffs (
    .word (scan_word),
    .found(scan_found),
    .pos  (scan_pos)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    frame_r    <= frame_nxt;
    k_r        <= k_nxt;
    ord_r      <= ord_nxt;
    over_r     <= over_nxt;
    nd_r       <= nd_nxt;
    wa_r       <= wa_nxt;
    set_r      <= set_nxt;
    out_data_r <= out_data_nxt;
    res_r      <= res_nxt;
  end

  always_comb begin
    logic [NB-1:0]     sib;
    logic [NB-1:0]     ndc;
    logic [NB-1:0]     blk;
    logic [WORD_W-1:0] bitm;
    logic [WORD_W-1:0] sibm;
    rsp_t              res;
    logic              fin;

    state_nxt     = state_r;
    mode_nxt      = mode_r;
    frame_nxt     = frame_r;
    k_nxt         = k_r;
    ord_nxt       = ord_r;
    over_nxt      = over_r;
    nd_nxt        = nd_r;
    wa_nxt        = wa_r;
    set_nxt       = set_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = nd_r[NB-1:WBIT];
    ram_wdata     = '0;
    ram_raddr     = nd_r[NB-1:WBIT];
    sib           = nd_r ^ NB'(1);
    bitm          = WORD_W'(1) << nd_r[WBIT-1:0];
    sibm          = WORD_W'(1) << sib[WBIT-1:0];
    ndc           = set_r ? (nd_r | NB'(1)) : nd_r;
    blk           = (ndc & ((NB'(1) << (FRAME_BITS - int'(k_r))) - NB'(1))) << k_r;
    res.frame_out = '0;
    res.flag      = 1'b0;
    fin           = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_data.mode;
          frame_nxt = FRAME_BITS'(in_data.frame);
          k_nxt     = in_k;
          over_nxt  = in_over;
          state_nxt = S_START;
        end
      end
      S_START: begin
        ord_nxt = k_r;
        nd_nxt  = node_at(k_r, frame_r);
        case (mode_r)
          MODE_ALLOC: begin
            wa_nxt    = first_word(k_r);
            state_nxt = S_SCAN_RD;
            if (over_r) begin
              fin = 1'b1;
            end
          end
          MODE_FREE: begin
            state_nxt = S_MERGE_RD;
            if (over_r) begin
              res.flag = 1'b1;
              fin      = 1'b1;
            end
          end
          MODE_QUERY: begin
            state_nxt = S_PROBE_RD;
          end
          default: begin
            state_nxt = S_PROBE_RD;
            if (over_r) begin
              fin = 1'b1;
            end
          end
        endcase
      end
      S_SCAN_RD: begin
        ram_raddr = wa_r;
        state_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (scan_found) begin
          nd_nxt    = {wa_r, scan_pos};
          set_nxt   = 1'b0;
          state_nxt = S_RMW_RD;
        end else if (wa_r == last_word(ord_r)) begin
          if (ord_r == TOP_ORD) begin
            fin = 1'b1;
          end else begin
            ord_nxt   = ord_r + ORD_W'(1);
            wa_nxt    = first_word(ord_r + ORD_W'(1));
            state_nxt = S_SCAN_RD;
          end
        end else begin
          wa_nxt    = wa_r + AW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_PROBE_RD: begin
        state_nxt = S_PROBE_EV;
      end
      S_PROBE_EV: begin
        if ((ram_rdata & bitm) != '0) begin
          if (mode_r == MODE_QUERY) begin
            fin = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~bitm;
            if (ord_r == k_r) begin
              res.frame_out = 16'((frame_r >> k_r) << k_r);
              res.flag      = 1'b1;
              fin           = 1'b1;
            end else begin
              ord_nxt   = ord_r - ORD_W'(1);
              nd_nxt    = node_at(ord_r - ORD_W'(1), frame_r) ^ NB'(1);
              set_nxt   = 1'b1;
              state_nxt = S_RMW_RD;
            end
          end
        end else if (ord_r == TOP_ORD) begin
          res.flag = (mode_r == MODE_QUERY);
          fin      = 1'b1;
        end else begin
          nd_nxt    = nd_r >> 1;
          ord_nxt   = ord_r + ORD_W'(1);
          state_nxt = S_PROBE_RD;
        end
      end
      S_MERGE_RD: begin
        if (ord_r == TOP_ORD) begin
          set_nxt   = 1'b1;
          state_nxt = S_RMW_RD;
        end else begin
          state_nxt = S_MERGE_EV;
        end
      end
      S_MERGE_EV: begin
        if ((ram_rdata & sibm) != '0) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~sibm;
          nd_nxt    = nd_r >> 1;
          ord_nxt   = ord_r + ORD_W'(1);
          state_nxt = S_MERGE_RD;
        end else begin
          set_nxt   = 1'b1;
          state_nxt = S_RMW_RD;
        end
      end
      S_RMW_RD: begin
        state_nxt = S_RMW_WR;
      end
      S_RMW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = set_r ? (ram_rdata | bitm) : (ram_rdata & ~bitm);
        case (mode_r)
          MODE_ALLOC: begin
            if (ord_r == k_r) begin
              res.frame_out = 16'(blk);
              res.flag      = 1'b1;
              fin           = 1'b1;
            end else begin
              nd_nxt    = ndc << 1;
              ord_nxt   = ord_r - ORD_W'(1);
              set_nxt   = 1'b1;
              state_nxt = S_RMW_RD;
            end
          end
          MODE_RESERVE: begin
            if (ord_r == k_r) begin
              res.frame_out = 16'((frame_r >> k_r) << k_r);
              res.flag      = 1'b1;
              fin           = 1'b1;
            end else begin
              ord_nxt   = ord_r - ORD_W'(1);
              nd_nxt    = node_at(ord_r - ORD_W'(1), frame_r) ^ NB'(1);
              set_nxt   = 1'b1;
              state_nxt = S_RMW_RD;
            end
          end
          default: begin
            res.flag = 1'b1;
            fin      = 1'b1;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      res_nxt   = res;
      state_nxt = S_DONE;
    end
  end

  `include "buddy_page_allocator_assert.svh"

  `BPA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request accepted twice")
  `BPA_ASSERT_SAME(a_scan_in_range, state_r == S_SCAN_EV, wa_r <= last_word(ord_r), "scan past order")
  `BPA_ASSERT_SAME(a_order_bound, state_r != S_IDLE && state_r != S_CLR && state_r != S_START && state_r != S_DONE, ord_r <= TOP_ORD, "order above top")

endmodule

>>> rtl/bpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bpa_ffs.sv
// Finds the lowest set bit of one bitmap word.
// Depends on bpa_pkg for the word width.
module bpa_ffs (
  input  logic [bpa_pkg::WORD_W-1:0] word,
  output logic                       found,
  output logic [bpa_pkg::WBIT-1:0]   pos
);
  import bpa_pkg::*;

  always_comb begin
    found = |word;
    pos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        pos = WBIT'(i);
      end
    end
  end

endmodule

>>> verif/buddy_page_allocator_tb.sv
// Self-checking testbench for the buddy page allocator.
// Depends on bpa_pkg and the buddy_page_allocator RTL; mirrors the free map in a local array.
module buddy_page_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int FB = 16;
  localparam int MO = 10;
  localparam int TOP = (MO < FB) ? MO : FB;
  localparam int WATCH_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  buddy_page_allocator #(.FRAME_BITS(FB), .MAX_ORDER(MO)) dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  bit   free_bits [0:(1 << (FB + 1)) - 1];
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   accepted = 0;
  int   checked = 0;
  int   idle_cycles = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   n_alloc_ok = 0;
  int   n_mode [4];

  function automatic int node_index(int k, int blk);
    int base;
    base = 1 << (FB - k);
    return base | (blk & (base - 1));
  endfunction

  function automatic bit node_free(int k, int blk);
    return free_bits[node_index(k, blk)];
  endfunction

  function automatic void mark(int k, int blk, bit v);
    free_bits[node_index(k, blk)] = v;
  endfunction

  function automatic int first_free_order(int k, int fr);
    for (int i = k; i <= TOP; i++)
      if (node_free(i, fr >> i)) return i;
    return -1;
  endfunction

  function automatic rsp_t predict_allocator(req_t r);
    rsp_t o;
    int fr, n, k, b, t;
    bit over, found;
    o = '0;
    fr = r.frame;
    n = r.n_pages;
    over = n > (1 << TOP);
    k = 0;
    if (over) k = TOP;
    else while (k < TOP && (1 << k) < n) k++;
    case (r.mode)
      MODE_ALLOC: begin
        found = 0;
        if (!over) begin
          for (int j = k; j <= TOP && !found; j++) begin
            for (b = 0; b < (1 << (FB - j)); b++) begin
              if (node_free(j, b)) begin
                mark(j, b, 0);
                for (int i = j; i > k; i--) begin
                  mark(i - 1, b << 1, 1);
                  b = (b << 1) | 1;
                end
                o.frame_out = 16'(b << k);
                o.flag = 1'b1;
                found = 1;
                break;
              end
            end
          end
        end
      end
      MODE_FREE: begin
        if (!over) begin
          b = fr >> k;
          while (k < TOP && node_free(k, b ^ 1)) begin
            mark(k, b ^ 1, 0);
            b >>= 1;
            k++;
          end
          mark(k, b, 1);
        end
        o.flag = 1'b1;
      end
      MODE_QUERY: o.flag = (first_free_order(k, fr) < 0);
      default: begin
        if (!over) begin
          t = first_free_order(k, fr);
          if (t >= 0) begin
            mark(t, fr >> t, 0);
            for (int i = t; i > k; i--) mark(i - 1, (fr >> (i - 1)) ^ 1, 1);
            o.frame_out = 16'(fr & ~((1 << k) - 1));
            o.flag = 1'b1;
          end
        end
      end
    endcase
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic req_t make_req(logic [1:0] m, int fr, int n);
    req_t r;
    r.mode = m;
    r.frame = 16'(fr);
    r.n_pages = 12'(n);
    return r;
  endfunction

  function automatic int rand_pages();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return $urandom_range(0, 8);
    if (p < 90) return $urandom_range(9, 1024);
    if (p < 95) return 1 << $urandom_range(0, 10);
    return $urandom_range(1025, 4095);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(predict_allocator(in_data));
        n_mode[in_data.mode]++;
        accepted++;
      end
      if (in_valid && !in_ready) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs.pop_front();
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        checked++;
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected result frame_out=%h flag=%b",
                   $time, out_data.frame_out, out_data.flag);
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (e.flag) n_alloc_ok++;
          if (e.frame_out !== out_data.frame_out) begin
            errors++;
            $display("%0t: frame_out expected %h actual %h",
                     $time, e.frame_out, out_data.frame_out);
          end
          if (e.flag !== out_data.flag) begin
            errors++;
            $display("%0t: flag expected %b actual %b", $time, e.flag, out_data.flag);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) recv_gap <= pick_gap();
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("FAIL buddy_page_allocator");
        $finish;
      end
    end
  end

  initial begin
    int b, sz, n;
    for (int i = 0; i < 8; i++) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty memory, oversized requests, then frees and edge frames.
    pending_reqs.push_back(make_req(MODE_ALLOC, 0, 1));
    pending_reqs.push_back(make_req(MODE_QUERY, 16'hffff, 0));
    pending_reqs.push_back(make_req(MODE_RESERVE, 0, 1));
    pending_reqs.push_back(make_req(MODE_FREE, 0, 4095));
    pending_reqs.push_back(make_req(MODE_QUERY, 16'h1234, 4095));
    pending_reqs.push_back(make_req(MODE_FREE, 0, 1024));
    pending_reqs.push_back(make_req(MODE_FREE, 16'hfc00, 1024));
    pending_reqs.push_back(make_req(MODE_FREE, 16'h0bff, 1000));
    pending_reqs.push_back(make_req(MODE_FREE, 16'h0800, 1024));
    pending_reqs.push_back(make_req(MODE_QUERY, 16'h0400, 1024));
    pending_reqs.push_back(make_req(MODE_ALLOC, 0, 0));
    pending_reqs.push_back(make_req(MODE_ALLOC, 0, 3));
    pending_reqs.push_back(make_req(MODE_ALLOC, 16'hffff, 1024));
    pending_reqs.push_back(make_req(MODE_ALLOC, 0, 1025));
    pending_reqs.push_back(make_req(MODE_RESERVE, 16'hfffe, 2));
    pending_reqs.push_back(make_req(MODE_RESERVE, 16'hfffe, 2));
    pending_reqs.push_back(make_req(MODE_QUERY, 16'hffff, 1));
    pending_reqs.push_back(make_req(MODE_FREE, 16'hfffd, 2));
    pending_reqs.push_back(make_req(MODE_FREE, 16'hfffd, 2));
    pending_reqs.push_back(make_req(MODE_RESERVE, 16'h0801, 4095));
    pending_reqs.push_back(make_req(MODE_ALLOC, 0, 1024));
    pending_reqs.push_back(make_req(MODE_QUERY, 16'h0000, 1));

    // Random: mostly alloc/free/reserve within a small populated region.
    for (int i = 0; i < 1150; i++) begin
      n = rand_pages();
      if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 65535);
      else b = $urandom_range(0, 8191);
      case ($urandom_range(0, 9))
        0, 1, 2: pending_reqs.push_back(make_req(MODE_ALLOC, $urandom, n));
        3, 4, 5: pending_reqs.push_back(make_req(MODE_FREE, b, n));
        6, 7: pending_reqs.push_back(make_req(MODE_QUERY, b, n));
        default: pending_reqs.push_back(make_req(MODE_RESERVE, b, n));
      endcase
    end
    wait (pending_reqs.size() == 0 && !in_valid && expected_rsps.size() == 0);
    sz = 0;
    while (sz < 200 && !out_valid) begin
      @(posedge clk);
      sz++;
    end
    @(posedge clk);
    $display("Covered %0d requests (alloc %0d, free %0d, query %0d, reserve %0d);",
             accepted, n_mode[0], n_mode[1], n_mode[2], n_mode[3]);
    $display("%0d results checked, %0d with flag set.", checked, n_alloc_ok);
    if (errors == 0 && expected_rsps.size() == 0 && !out_valid) begin
      $display("PASS buddy_page_allocator");
    end else begin
      $display("FAIL buddy_page_allocator");
    end
    $finish;
  end
endmodule
